[rtl/isp_pkg.sv]
// shared types, constants and register codes for the interpolating sample player
package isp_pkg;

  // sizes
  localparam int FRAC_W  = 16;                 // fraction bits of the phase
  localparam int ADDR_W  = 16;                 // sample memory address width
  localparam int DATA_W  = 16;                 // sample word width
  localparam int LEN_W   = ADDR_W + 1;         // length register width
  localparam int PHASE_W = ADDR_W + FRAC_W;    // 16.16 phase
  localparam int INC_W   = 24;                 // 8.16 increment
  localparam int VEL_W   = 7;
  localparam int CFG_W   = 24;                 // widest register
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(1 << ADDR_W);

  // gain (vel + 32) / 160 = (vel + 32) / (5 * 32); the 32 folds into the shift
  localparam logic [VEL_W:0] GAIN_OFS = (VEL_W+1)'(32);
  localparam int ROUND_SHIFT = FRAC_W + 5;
  localparam int HALF_DEN    = 5 << (ROUND_SHIFT - 1);
  // floor(t / 5) = (t * RECIP5) >> RECIP_SHIFT, exact for t below 2^20
  localparam int RECIP_SHIFT = 23;
  localparam logic [20:0] RECIP5 = 21'((1 << RECIP_SHIFT) / 5 + 1);

  // operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RENDER = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY        = 2'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic [ADDR_W-1:0]        load_address;
    logic signed [DATA_W-1:0] load_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_out;
    logic                     playing;
  } result_t;

  // stage strobes for the arithmetic pipeline
  typedef struct packed {
    logic cap0;
    logic mul;
    logic scale;
    logic round;
    logic div;
  } mix_ctl_t;

endpackage

[rtl/interpolating_sample_player_top.sv]
// interpolating sample player: sequencer, phase and config registers
// load and start give no result; a render of an inactive or finished voice goes straight to the
// output state; an active render reads the ram twice, and waits longer on the modulo unit when
// the advanced phase passes the length, longer still when the phase already lies beyond a
// shortened length; a stalled result register adds its wait; one transaction at a time; reset
// is synchronous: voice inactive, phase 0, registers at defaults
module interpolating_sample_player_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  isp_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output isp_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [isp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isp_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_IDX   = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_ROUND = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int AW = isp_pkg::ADDR_W;
  localparam int FW = isp_pkg::FRAC_W;
  localparam int LW = isp_pkg::LEN_W;

  logic [3:0]                  state;
  logic [isp_pkg::PHASE_W-1:0] phase;
  logic                        active;
  logic [LW-1:0]               sample_length;
  logic [isp_pkg::INC_W-1:0]   phase_increment;
  logic                        loop_enable;
  logic [isp_pkg::VEL_W-1:0]   velocity;
  logic [AW-1:0]               i0;
  logic [AW-1:0]               i1;
  logic                        zero_res;

  logic                        item_acc;
  logic [LW-1:0]               len_eff;
  logic [LW:0]                 whole_p2;
  logic                        stop;
  logic [isp_pkg::PHASE_W:0]   phase_sum;
  logic [LW-1:0]               idx_next;
  logic                        rem_start;
  logic [LW-1:0]               rem_dividend;
  logic                        rem_busy;
  logic [LW-1:0]               rem_res;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [isp_pkg::DATA_W-1:0]  ram_rdata;
  isp_pkg::mix_ctl_t           mix_ctl;
  logic signed [isp_pkg::DATA_W-1:0] mix_res;

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;

  // effective length clamped to 1..max
  always_comb begin
    if (sample_length == '0) begin
      len_eff = LW'(1);
    end else if (sample_length > isp_pkg::MAX_LEN) begin
      len_eff = isp_pkg::MAX_LEN;
    end else begin
      len_eff = sample_length;
    end
  end

  // one-shot end test and phase advance
  assign whole_p2  = (LW+1)'(phase[isp_pkg::PHASE_W-1:FW]) + (LW+1)'(2);
  assign stop      = (whole_p2 > {1'b0, len_eff}) && !loop_enable;
  assign phase_sum = (isp_pkg::PHASE_W+1)'(phase) + (isp_pkg::PHASE_W+1)'(phase_increment);
  // neighbor index wraps to zero at the length
  assign idx_next  = rem_res + LW'(1);

  // modulo unit requests: read index at accept, new whole part after the reads
  assign rem_start = (item_acc && item.operation == isp_pkg::OP_RENDER && active && !stop)
                  || (state == S_MUL);
  assign rem_dividend = (state == S_MUL) ? phase_sum[isp_pkg::PHASE_W:FW]
                                         : LW'(phase[isp_pkg::PHASE_W-1:FW]);

  // ram access
  assign ram_we    = item_acc && item.operation == isp_pkg::OP_LOAD;
  assign ram_re    = (state == S_RD0) || (state == S_RD1);
  assign ram_raddr = (state == S_RD1) ? i1 : i0;

  // pipeline strobes
  assign mix_ctl.cap0  = (state == S_RD1);
  assign mix_ctl.mul   = (state == S_MUL);
  assign mix_ctl.scale = (state == S_SCALE);
  assign mix_ctl.round = (state == S_ROUND);
  assign mix_ctl.div   = (state == S_DIV);

  isp_ram #(
    .AW(AW),
    .DW(isp_pkg::DATA_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(item.load_address),
    .wdata(item.load_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  isp_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .dividend(rem_dividend),
    .divisor (len_eff),
    .busy    (rem_busy),
    .result  (rem_res)
  );

  isp_mix u_mix (
    .clk     (clk),
    .ctl     (mix_ctl),
    .rdata   ($signed(ram_rdata)),
    .frac    (phase[FW-1:0]),
    .velocity(velocity),
    .res     (mix_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_length   <= LW'(2);
      phase_increment <= isp_pkg::INC_W'(1 << FW);
      loop_enable     <= 1'b0;
      velocity        <= isp_pkg::VEL_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        isp_pkg::REG_SAMPLE_LENGTH:   sample_length   <= cfg_data[LW-1:0];
        isp_pkg::REG_PHASE_INCREMENT: phase_increment <= cfg_data[isp_pkg::INC_W-1:0];
        isp_pkg::REG_LOOP_ENABLE:     loop_enable     <= cfg_data[0];
        isp_pkg::REG_VELOCITY:        velocity        <= cfg_data[isp_pkg::VEL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, phase and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= '0;
      active <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            case (item.operation)
              isp_pkg::OP_START: begin
                phase  <= '0;
                active <= 1'b1;
              end
              isp_pkg::OP_RENDER: begin
                if (!active) begin
                  state <= S_OUT;
                end else if (stop) begin
                  active <= 1'b0;
                  state  <= S_OUT;
                end else begin
                  state <= S_IDX;
                end
              end
              default: ;
            endcase
          end
        end
        S_IDX: begin
          if (!rem_busy) begin
            state <= S_RD0;
          end
        end
        S_RD0:   state <= S_RD1;
        S_RD1:   state <= S_MUL;
        S_MUL:   state <= S_SCALE;
        S_SCALE: state <= S_ROUND;
        S_ROUND: state <= S_DIV;
        S_DIV:   state <= S_WAIT;
        S_WAIT: begin
          if (!rem_busy) begin
            phase <= {rem_res[AW-1:0], phase_sum[FW-1:0]};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read indexes and result kind
  always_ff @(posedge clk) begin
    if (state == S_IDX && !rem_busy) begin
      i0 <= rem_res[AW-1:0];
      i1 <= (idx_next == len_eff) ? '0 : idx_next[AW-1:0];
    end
    if (item_acc) begin
      zero_res <= 1'b1;
    end else if (state == S_WAIT) begin
      zero_res <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || !result_stall)) begin
      result.sample_out <= zero_res ? '0 : mix_res;
      result.playing    <= !zero_res;
    end
  end

  // a new result only comes out of the output state
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  // a silent result carries zero
  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.playing) |-> result.sample_out == '0)
    else $error("stopped voice gave a nonzero sample");

  // ram read indexes lie inside the length
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD0) |-> ((LW'(i0) < len_eff) && (LW'(i1) < len_eff)))
    else $error("read index beyond sample length");

  // the modulo unit is never restarted while busy
  a_rem_free: assert property (@(posedge clk) disable iff (rst)
    rem_start |-> !rem_busy)
    else $error("modulo unit restarted while busy");

endmodule

[rtl/isp_ram.sv]
// single-port-write, single-port-read sample ram with registered read data
module isp_ram #(
  parameter int AW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/isp_rem.sv]
// bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle while busy
module isp_rem (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [isp_pkg::LEN_W-1:0] dividend,
  input  logic [isp_pkg::LEN_W-1:0] divisor,
  output logic                     busy,
  output logic [isp_pkg::LEN_W-1:0] result
);

  localparam int CNT_W = $clog2(isp_pkg::LEN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(isp_pkg::LEN_W - 1);

  logic [isp_pkg::LEN_W-1:0] dvd;
  logic [isp_pkg::LEN_W-1:0] dvs;
  logic [isp_pkg::LEN_W-1:0] rem;
  logic [CNT_W-1:0]          cnt;
  logic                      quick;
  logic [isp_pkg::LEN_W:0]   rem_sh;

  // shift in the next dividend bit
  assign rem_sh = {rem, dvd[isp_pkg::LEN_W-1]};
  assign result = rem;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (quick || cnt == LAST)) begin
      busy <= 1'b0;
    end
  end

  // datapath: already reduced values are copied to the remainder without the serial steps
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      cnt   <= '0;
      quick <= dividend < divisor;
    end else if (busy) begin
      if (quick) begin
        rem <= dvd;
      end else begin
        dvd <= dvd << 1;
        cnt <= cnt + CNT_W'(1);
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= isp_pkg::LEN_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= isp_pkg::LEN_W'(rem_sh);
        end
      end
    end
  end

endmodule

[rtl/isp_mix.sv]
// interpolation and velocity scaling pipeline, one stage per strobe
module isp_mix (
  input  logic                            clk,
  input  isp_pkg::mix_ctl_t               ctl,
  input  logic signed [isp_pkg::DATA_W-1:0] rdata,
  input  logic [isp_pkg::FRAC_W-1:0]      frac,
  input  logic [isp_pkg::VEL_W-1:0]       velocity,
  output logic signed [isp_pkg::DATA_W-1:0] res
);

  localparam int DIFF_W   = isp_pkg::DATA_W + 1;
  localparam int PROD_W   = DIFF_W + isp_pkg::FRAC_W + 1;
  localparam int INTERP_W = isp_pkg::DATA_W + isp_pkg::FRAC_W + 1;
  localparam int GAIN_W   = isp_pkg::VEL_W + 2;
  localparam int SCALED_W = INTERP_W + GAIN_W;
  localparam int T_W      = 20;

  logic signed [isp_pkg::DATA_W-1:0] s0;
  logic signed [DIFF_W-1:0]          diff;
  logic signed [PROD_W-1:0]          prod;
  logic signed [INTERP_W-1:0]        interp;
  logic [isp_pkg::VEL_W:0]           gain;
  logic signed [SCALED_W-1:0]        scaled;
  logic [SCALED_W-1:0]               mag;
  logic [SCALED_W-1:0]               mag_rnd;
  logic                              neg;
  logic [T_W-1:0]                    t;
  logic [T_W+20:0]                   qprod;
  logic [isp_pkg::DATA_W-1:0]        q;

  // s1 - s0, weighted by the fraction in the mul stage
  assign diff = DIFF_W'(rdata) - DIFF_W'(s0);
  // s0 * 2^F + (s1 - s0) * frac, always within 33 bits
  assign interp = $signed({s0[isp_pkg::DATA_W-1], s0, {isp_pkg::FRAC_W{1'b0}}})
                + INTERP_W'(prod);
  assign gain = {1'b0, velocity} + isp_pkg::GAIN_OFS;
  // magnitude plus half the divisor for round half away from zero
  assign mag     = scaled[SCALED_W-1] ? SCALED_W'(-scaled) : SCALED_W'(scaled);
  assign mag_rnd = mag + SCALED_W'(isp_pkg::HALF_DEN);
  // divide by five through the reciprocal
  assign qprod = (T_W+21)'(t) * (T_W+21)'(isp_pkg::RECIP5);
  assign q     = qprod[isp_pkg::RECIP_SHIFT +: isp_pkg::DATA_W];

  // pipeline stages
  always_ff @(posedge clk) begin
    if (ctl.cap0) begin
      s0 <= rdata;
    end
    if (ctl.mul) begin
      prod <= diff * $signed({1'b0, frac});
    end
    if (ctl.scale) begin
      scaled <= interp * $signed({1'b0, gain});
    end
    if (ctl.round) begin
      neg <= scaled[SCALED_W-1];
      t   <= mag_rnd[isp_pkg::ROUND_SHIFT +: T_W];
    end
    if (ctl.div) begin
      res <= neg ? $signed(-q) : $signed(q);
    end
  end

endmodule
